[sv/ordered_list_insert_remove_macros.svh]
// Assertion macros used by the ordered list sequencer.
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define OLIR_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define OLIR_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define OLIR_ASSERT(lbl, clk, rstn, prop, msg)
`define OLIR_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[sv/olir_pkg.sv]
// Types and constants for the ordered list block.
package olir_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KIND_W    = 2;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 8;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_APPLY
	} state_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     live;    // cell holds a valid entry
		logic     rd_sel;  // cell is the read target
	} cell_ctl_t;

endpackage

[sv/olir_cell.sv]
// One list cell: holds an entry, compares it, shifts to/from its neighbors.
module olir_cell (
	input  logic                              clk,
	input  olir_pkg::cell_ctl_t               ctl,
	input  logic [olir_pkg::VALUE_W-1:0]      left_data,
	input  logic [olir_pkg::VALUE_W-1:0]      right_data,
	input  logic [olir_pkg::VALUE_W-1:0]      op_value,
	output logic [olir_pkg::VALUE_W-1:0]      data_q,
	output logic                              match_q,
	output logic [olir_pkg::VALUE_W-1:0]      rd_q
);

	always_ff @(posedge clk) begin
		case (ctl.op)
			olir_pkg::CELL_LEFT:  data_q <= left_data;
			olir_pkg::CELL_RIGHT: data_q <= right_data;
			olir_pkg::CELL_LOAD:  data_q <= op_value;
			default:              data_q <= data_q;
		endcase
	end

	// compare and read-select, registered for the next cycle
	always_ff @(posedge clk) begin
		match_q <= ctl.live && (data_q == op_value);
		rd_q    <= ctl.rd_sel ? data_q : '0;
	end

endmodule

[sv/olir_ctrl.sv]
// Sequencer: op latch, per-cell control, first-match prefix, result register.
`include "ordered_list_insert_remove_macros.svh"
module olir_ctrl #(
	parameter int DEPTH = olir_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  olir_pkg::kind_t                   in_kind,
	input  logic [olir_pkg::VALUE_W-1:0]      in_value,
	input  logic [olir_pkg::POS_W-1:0]        in_position,
	input  logic [DEPTH-1:0]                  match,
	input  logic [olir_pkg::VALUE_W-1:0]      rd_or,
	output olir_pkg::cell_ctl_t               cell_ctl [DEPTH],
	output logic [olir_pkg::VALUE_W-1:0]      op_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output olir_pkg::status_t                 out_status,
	output logic [olir_pkg::VALUE_W-1:0]      out_read_value,
	output logic [olir_pkg::COUNT_W-1:0]      out_count
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int XW  = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;
	localparam int LVL = $clog2(DEPTH);

	olir_pkg::state_t                 state_q, state_d;
	olir_pkg::kind_t                  kind_q;
	logic [olir_pkg::VALUE_W-1:0]     value_q;
	logic [olir_pkg::POS_W-1:0]       pos_q;
	logic [CW-1:0]                    count_q, count_d;
	logic                             out_valid_q;
	olir_pkg::status_t                status_q, status_d;
	logic [olir_pkg::VALUE_W-1:0]     rdval_q, rdval_d;

	logic [XW-1:0]    pos_x, cnt_x, pos_eff;
	logic             full, adv, apply, ins_ok, found;
	logic [DEPTH-1:0] incl;

	assign pos_x    = XW'(pos_q);
	assign cnt_x    = XW'(count_q);
	assign full     = (count_q == CW'(DEPTH));
	assign pos_eff  = ((kind_q == olir_pkg::KIND_APPEND) || (pos_x > cnt_x)) ? cnt_x : pos_x;
	assign adv      = !out_valid_q || out_ready;
	assign apply    = (state_q == olir_pkg::ST_APPLY) && adv;
	assign ins_ok   = ((kind_q == olir_pkg::KIND_APPEND) || (kind_q == olir_pkg::KIND_INSERT))
	                  && !full;
	assign found    = |match;
	assign in_ready = (state_q == olir_pkg::ST_IDLE);
	assign op_value = value_q;

	// inclusive prefix OR: incl[i] set when some cell at or below i matched
	always_comb begin
		incl = match;
		for (int k = 0; k < LVL; k++) begin
			incl = incl | (incl << (1 << k));
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].live   = XW'(i) < cnt_x;
			cell_ctl[i].rd_sel = (XW'(i) == pos_x) && (XW'(i) < cnt_x);
			cell_ctl[i].op     = olir_pkg::CELL_HOLD;
			if (apply) begin
				if (ins_ok) begin
					if (XW'(i) == pos_eff)
						cell_ctl[i].op = olir_pkg::CELL_LOAD;
					else if (XW'(i) > pos_eff)
						cell_ctl[i].op = olir_pkg::CELL_LEFT;
				end else if (kind_q == olir_pkg::KIND_REMOVE && incl[i]) begin
					cell_ctl[i].op = olir_pkg::CELL_RIGHT;
				end
			end
		end
	end

	// result of the op in flight
	always_comb begin
		count_d  = count_q;
		rdval_d  = '0;
		status_d = olir_pkg::STAT_OK;
		unique case (kind_q)
			olir_pkg::KIND_APPEND, olir_pkg::KIND_INSERT: begin
				if (full)
					status_d = olir_pkg::STAT_FULL;
				else
					count_d = count_q + 1'b1;
			end
			olir_pkg::KIND_REMOVE: begin
				if (found)
					count_d = count_q - 1'b1;
				else
					status_d = olir_pkg::STAT_NOT_FOUND;
			end
			olir_pkg::KIND_READ: begin
				if (pos_x < cnt_x)
					rdval_d = rd_or;
				else
					status_d = olir_pkg::STAT_RANGE;
			end
			default: status_d = olir_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olir_pkg::ST_IDLE:  if (in_valid) state_d = olir_pkg::ST_EVAL;
			olir_pkg::ST_EVAL:  state_d = olir_pkg::ST_APPLY;
			olir_pkg::ST_APPLY: if (adv) state_d = olir_pkg::ST_IDLE;
			default:            state_d = olir_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olir_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= in_kind;
			value_q <= in_value;
			pos_q   <= in_position;
		end
		if (apply) begin
			status_q <= status_d;
			rdval_q  <= rdval_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = status_q;
	assign out_read_value = rdval_q;
	assign out_count      = olir_pkg::COUNT_W'(count_q);

	`OLIR_NEVER(a_count_bound, clk, arst_n, count_q > CW'(DEPTH), "count above capacity")
	`OLIR_ASSERT(a_first_match, clk, arst_n, (state_q != olir_pkg::ST_APPLY) || $onehot0(match & ~(incl << 1)), "more than one first match")
	`OLIR_ASSERT(a_ins_count, clk, arst_n, (apply && ins_ok) |=> (count_q == $past(count_q) + 1'b1), "insert did not grow count")

endmodule

[sv/ordered_list_insert_remove.sv]
// Top level of the ordered list: a chain of entry cells under one sequencer.
//
// Fixed-capacity ordered list of signed 32-bit entries held in a row of DEPTH
// cells. Each input beat carries one op: append, insert at a position, remove
// the first equal entry, or read the entry at an index. Each op yields exactly
// one output beat with a status, the read value (zero unless a good read) and
// the entry count after the op.
// Input: s_tvalid/s_tready, s_tdata = value then position, s_tuser = kind.
// Output: m_tvalid/m_tready, m_tdata = read_value then count, m_tuser = status.
// Each op is latched on acceptance, then passes a compare state in which
// every cell checks its entry in parallel, then a shift state in which the
// cells above the insert point move up one place, or the cells from the
// first match up close the removal gap, all at once; m_tvalid rises as the
// shift state completes. A new op is taken only once the last has left it.
// The output register frees the input side: a new beat is taken while the
// last result still waits. A stalled receiver holds the op in its shift cycle
// until the output register drains, so no result is lost.
// Reset clears the count and handshake state; entries are never cleared, as
// only entries below the count are ever compared or read.
module ordered_list_insert_remove #(
	parameter int DEPTH = olir_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [39:32] position
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] count, [39] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int VW = olir_pkg::VALUE_W;

	olir_pkg::cell_ctl_t  cell_ctl [DEPTH];
	logic [VW-1:0]        data   [DEPTH];
	logic [VW-1:0]        rd     [DEPTH];
	logic [DEPTH-1:0]     match;
	logic [VW-1:0]        op_value, rd_or, read_value;
	olir_pkg::status_t    status;
	logic [olir_pkg::COUNT_W-1:0] count;

	olir_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_kind        (olir_pkg::kind_t'(s_tuser)),
		.in_value       (s_tdata[31:0]),
		.in_position    (s_tdata[39:32]),
		.match          (match),
		.rd_or          (rd_or),
		.cell_ctl       (cell_ctl),
		.op_value       (op_value),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_status     (status),
		.out_read_value (read_value),
		.out_count      (count)
	);

	// the chain: cell i takes from i-1 on insert, from i+1 on remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VW-1:0] left_in, right_in;
		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in = data[i];
		end else begin : g_mid_r
			assign right_in = data[i+1];
		end
		olir_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_in),
			.right_data (right_in),
			.op_value   (op_value),
			.data_q     (data[i]),
			.match_q    (match[i]),
			.rd_q       (rd[i])
		);
	end

	// at most one cell drives a nonzero read word; OR per bit column
	always_comb begin
		logic [DEPTH-1:0] col;
		col = '0;
		for (int b = 0; b < VW; b++) begin
			for (int i = 0; i < DEPTH; i++) begin
				col[i] = rd[i][b];
			end
			rd_or[b] = |col;
		end
	end

	assign m_tdata = {1'b0, count, read_value};
	assign m_tuser = status;

endmodule
